>>> rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, fixed-point constants and the CORDIC arctangent table for
// the differential-drive odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

    // angles in 2^-24 rad
    localparam int TWO_PI_Q    = 105414357;
    localparam int PI_Q        = 52707179;
    localparam int HALF_PI_Q   = 26353589;
    // CORDIC start gain, Q1.30
    localparam int CORDIC_GAIN = 652032874;

    localparam int MUL_W  = 35;          // shared multiplier operand width
    localparam int PROD_W = 2 * MUL_W;
    localparam int TRV_W  = 34;          // wheel travel width
    localparam int CS_W   = 34;          // CORDIC x/y/z width
    localparam int PHI_W  = 30;          // CORDIC input angle width
    localparam int NUM_W  = 64;          // divider numerator
    localparam int DEN_W  = 34;          // divider denominator

    // configuration register indexes
    localparam logic [2:0] CFG_RIGHT_REVERSE = 3'd0;
    localparam logic [2:0] CFG_LEFT_REVERSE  = 3'd1;
    localparam logic [2:0] CFG_RIGHT_SCALE   = 3'd2;
    localparam logic [2:0] CFG_LEFT_SCALE    = 3'd3;
    localparam logic [2:0] CFG_RIGHT_ARM     = 3'd4;
    localparam logic [2:0] CFG_LEFT_ARM      = 3'd5;
    localparam logic [2:0] CFG_THRESHOLD     = 3'd6;
    localparam logic [2:0] CFG_COUNT_OFFSET  = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_TR,
        ST_MUL_TL,
        ST_MUL_D1,
        ST_MUL_D2,
        ST_SUM,
        ST_DIV_D,
        ST_DIV_A,
        ST_COR1,
        ST_MUL_C,
        ST_DIVC_GO,
        ST_DIV_C,
        ST_COR2,
        ST_MUL_X,
        ST_MUL_Y,
        ST_UPD
    } t_state;

    // atan(2^-k) in Q30
    function automatic logic [29:0] atan_q30(input logic [4:0] k);
        logic [29:0] v;
        case (k)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            5'd24: v = 30'd64;
            5'd25: v = 30'd32;
            5'd26: v = 30'd16;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/ddo_div.sv
// ----------------------------------------------------------------------------
// ddo_div
// Signed truncating divider, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddo_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [ddo_pkg::NUM_W-1:0]  i_num,
    input  logic signed [ddo_pkg::DEN_W-1:0]  i_den,
    output logic                              o_done,
    output logic signed [ddo_pkg::NUM_W:0]    o_quo
);
    localparam int NW = ddo_pkg::NUM_W;
    localparam int DW = ddo_pkg::DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_neg;
    logic          r_done;

    logic [DW:0]   trial;
    logic [DW:0]   diff;

    assign trial = {r_rem, r_quo[NW-1]};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r_den <= i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
            r_neg <= i_num[NW-1] ^ i_den[DW-1];
            r_rem <= '0;
        end else if (r_busy) begin
            if (!diff[DW]) begin
                r_rem <= diff[DW-1:0];
                r_quo <= {r_quo[NW-2:0], 1'b1};
            end else begin
                r_rem <= trial[DW-1:0];
                r_quo <= {r_quo[NW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -signed'({1'b0, r_quo}) : signed'({1'b0, r_quo});

endmodule

>>> rtl/ddo_cordic.sv
// ----------------------------------------------------------------------------
// ddo_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, sin and cos in Q1.30.
// ----------------------------------------------------------------------------
module ddo_cordic #(
    parameter int STEPS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [ddo_pkg::PHI_W-1:0]  i_phi,
    output logic                              o_done,
    output logic signed [ddo_pkg::CS_W-1:0]   o_sin,
    output logic signed [ddo_pkg::CS_W-1:0]   o_cos
);
    localparam int W  = ddo_pkg::CS_W;
    localparam int PW = ddo_pkg::PHI_W;
    localparam int CW = $clog2(STEPS + 1);

    logic signed [W-1:0] r_x, r_y, r_z;
    logic [CW-1:0]       r_cnt;
    logic                r_busy;
    logic                r_neg;
    logic                r_done;

    logic signed [PW-1:0] fold;
    logic                 fold_neg;
    logic [4:0]           k;
    logic signed [W-1:0]  xs, ys, at;

    // bring the angle into [-pi/2, pi/2], remembering a half-turn
    always_comb begin
        fold     = i_phi;
        fold_neg = 1'b0;
        if (fold > PW'(ddo_pkg::PI_Q))  fold = fold - PW'(ddo_pkg::TWO_PI_Q);
        if (fold > PW'(ddo_pkg::PI_Q))  fold = fold - PW'(ddo_pkg::TWO_PI_Q);
        if (fold < -PW'(ddo_pkg::PI_Q)) fold = fold + PW'(ddo_pkg::TWO_PI_Q);
        if (fold < -PW'(ddo_pkg::PI_Q)) fold = fold + PW'(ddo_pkg::TWO_PI_Q);
        if (fold > PW'(ddo_pkg::HALF_PI_Q)) begin
            fold     = fold - PW'(ddo_pkg::PI_Q);
            fold_neg = 1'b1;
        end else if (fold < -PW'(ddo_pkg::HALF_PI_Q)) begin
            fold     = fold + PW'(ddo_pkg::PI_Q);
            fold_neg = 1'b1;
        end
    end

    assign k  = 5'(STEPS - 32'(r_cnt));
    assign xs = r_x >>> k;
    assign ys = r_y >>> k;
    assign at = signed'(W'(ddo_pkg::atan_q30(k)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= W'(ddo_pkg::CORDIC_GAIN);
            r_y   <= '0;
            r_z   <= W'(fold) <<< 6;
            r_neg <= fold_neg;
        end else if (r_busy) begin
            if (!r_z[W-1]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_neg ? -r_y : r_y;
    assign o_cos  = r_neg ? -r_x : r_x;

endmodule

>>> rtl/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Arc-update odometry: wheel counts in, position / heading / step out.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                   Payload
// in        sink       i_in_valid / o_in_stall     i_right_count, i_left_count
// out       source     o_out_valid / i_out_stall   o_x_position, o_y_position,
//                                                  o_heading, o_step_distance,
//                                                  o_step_angle
// cfg       sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One item runs from its transfer to the next possible input transfer
// through the travel and step multiplies, the 64-bit bit-serial step and
// angle divides, the chord CORDIC pass, multiply and divide, the heading
// CORDIC pass and the update when the arc chord is used. A straight step
// skips all chord work and a zero wheel base skips both step divides too.
// Synchronous active-low reset clears position and heading to zero and
// loads the register defaults. A finished result sits in the output
// register while the next transfer is accepted and processed; only the
// final load waits on i_out_stall, adding its stall cycles.
//
module differential_drive_odometry #(
    parameter int CORDIC_STEPS   = 24,
    parameter int POSITION_WIDTH = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_right_count,
    input  logic [15:0]        i_left_count,
    // result item
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [47:0] o_x_position,
    output logic signed [47:0] o_y_position,
    output logic signed [27:0] o_heading,
    output logic signed [31:0] o_step_distance,
    output logic signed [27:0] o_step_angle,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);
    localparam int MW  = ddo_pkg::MUL_W;
    localparam int PRW = ddo_pkg::PROD_W;
    localparam int TW  = ddo_pkg::TRV_W;
    localparam int CSW = ddo_pkg::CS_W;
    localparam int PHW = ddo_pkg::PHI_W;
    localparam int NW  = ddo_pkg::NUM_W;
    localparam int DW  = ddo_pkg::DEN_W;
    localparam int PW  = POSITION_WIDTH;

    // configuration
    logic        r_rrev, r_lrev;
    logic [23:0] r_rscale, r_lscale, r_thresh;
    logic [19:0] r_rarm, r_larm;
    logic [15:0] r_offset;

    // sequencer and datapath
    ddo_pkg::t_state r_state, n_state;
    logic [15:0]            r_cnt_r, r_cnt_l;
    logic signed [TW-1:0]   r_tr, r_tl;
    logic signed [55:0]     r_acc;
    logic signed [PRW-1:0]  r_prod;
    logic signed [31:0]     r_dist, r_chord;
    logic signed [27:0]     r_ang;
    logic signed [PW-1:0]   r_pos_x, r_pos_y;
    logic signed [27:0]     r_head;

    // output register
    logic                   r_out_valid;
    logic signed [47:0]     r_ox, r_oy;
    logic signed [27:0]     r_oh, r_oa;
    logic signed [31:0]     r_od;

    // control decode
    logic                   mul_en;
    logic signed [MW-1:0]   mul_a, mul_b;
    logic                   div_start;
    logic signed [NW-1:0]   div_num;
    logic signed [DW-1:0]   div_den;
    logic                   cor_start;
    logic signed [PHW-1:0]  cor_phi;

    logic                   div_done, cor_done;
    logic signed [NW:0]     div_quo;
    logic signed [CSW-1:0]  sn, cs;

    logic                   in_xfer, out_free;
    logic signed [16:0]     diff_r, diff_l;
    logic [20:0]            base;
    logic signed [TW-1:0]   trav;
    logic signed [NW-1:0]   num_d, num_a;
    logic signed [34:0]     tdiff;
    logic signed [31:0]     dist_c, chord_c;
    logic signed [27:0]     ang_c;
    logic                   use_arc;
    logic signed [PRW-1:0]  neg_prod, dx_full, dy_full;
    logic signed [28:0]     head_sum, head_c;
    logic signed [63:0]     px64, py64;

    function automatic logic signed [31:0] sat32(input logic signed [NW:0] v);
        if (v > (NW+1)'(32'sh7FFF_FFFF))      return 32'sh7FFF_FFFF;
        else if (v < -(NW+1)'(33'sh8000_0000)) return 32'sh8000_0000;
        else                                   return 32'(v);
    endfunction

    function automatic logic signed [27:0] sat_ang(input logic signed [NW:0] v);
        if (v > (NW+1)'(ddo_pkg::TWO_PI_Q))       return 28'(ddo_pkg::TWO_PI_Q);
        else if (v < -(NW+1)'(ddo_pkg::TWO_PI_Q)) return -28'(ddo_pkg::TWO_PI_Q);
        else                                      return 28'(v);
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ddo_pkg::ST_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    // offset removal, 17-bit signed
    assign diff_r = signed'({1'b0, r_cnt_r}) - signed'({1'b0, r_offset});
    assign diff_l = signed'({1'b0, r_cnt_l}) - signed'({1'b0, r_offset});
    assign base   = {1'b0, r_rarm} + {1'b0, r_larm};

    // wheel travel = floor(diff*scale / 2^8), negated on reverse
    always_comb begin
        trav = TW'(signed'(r_prod[40:8]));
        if ((r_state == ddo_pkg::ST_MUL_TL && r_rrev) ||
            (r_state == ddo_pkg::ST_MUL_D1 && r_lrev)) begin
            trav = -trav;
        end
    end

    assign num_d   = NW'(r_acc) + NW'(signed'(r_prod[55:0]));
    assign tdiff   = 35'(r_tr) - 35'(r_tl);
    assign num_a   = NW'(tdiff) <<< 16;
    assign dist_c  = sat32(div_quo);
    assign chord_c = sat32(div_quo);
    assign ang_c   = sat_ang(div_quo);
    // signed compare: negative steps always take the straight chord
    assign use_arc = (29'(ang_c) >= signed'({5'b0, r_thresh})) && (ang_c != '0);

    assign neg_prod = -r_prod;
    assign dx_full  = neg_prod >>> 30;
    assign dy_full  = r_prod >>> 30;

    // truncated remainder of 2*pi, sum stays within two turns
    always_comb begin
        head_sum = 29'(r_head) + 29'(r_ang);
        head_c   = head_sum;
        if (head_sum >= 29'(ddo_pkg::TWO_PI_Q)) begin
            head_c = head_sum - 29'(ddo_pkg::TWO_PI_Q);
        end else if (head_sum <= -29'(ddo_pkg::TWO_PI_Q)) begin
            head_c = head_sum + 29'(ddo_pkg::TWO_PI_Q);
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ddo_pkg::ST_IDLE:    if (in_xfer) n_state = ddo_pkg::ST_MUL_TR;
            ddo_pkg::ST_MUL_TR:  n_state = ddo_pkg::ST_MUL_TL;
            ddo_pkg::ST_MUL_TL:  n_state = ddo_pkg::ST_MUL_D1;
            ddo_pkg::ST_MUL_D1:  n_state = ddo_pkg::ST_MUL_D2;
            ddo_pkg::ST_MUL_D2:  n_state = ddo_pkg::ST_SUM;
            ddo_pkg::ST_SUM:     n_state = (base == '0) ? ddo_pkg::ST_COR2
                                                        : ddo_pkg::ST_DIV_D;
            ddo_pkg::ST_DIV_D:   if (div_done) n_state = ddo_pkg::ST_DIV_A;
            ddo_pkg::ST_DIV_A: begin
                if (div_done) begin
                    n_state = use_arc ? ddo_pkg::ST_COR1 : ddo_pkg::ST_COR2;
                end
            end
            ddo_pkg::ST_COR1:    if (cor_done) n_state = ddo_pkg::ST_MUL_C;
            ddo_pkg::ST_MUL_C:   n_state = ddo_pkg::ST_DIVC_GO;
            ddo_pkg::ST_DIVC_GO: n_state = ddo_pkg::ST_DIV_C;
            ddo_pkg::ST_DIV_C:   if (div_done) n_state = ddo_pkg::ST_COR2;
            ddo_pkg::ST_COR2:    if (cor_done) n_state = ddo_pkg::ST_MUL_X;
            ddo_pkg::ST_MUL_X:   n_state = ddo_pkg::ST_MUL_Y;
            ddo_pkg::ST_MUL_Y:   n_state = ddo_pkg::ST_UPD;
            ddo_pkg::ST_UPD:     if (out_free) n_state = ddo_pkg::ST_IDLE;
            default:             n_state = ddo_pkg::ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = num_d;
        div_den   = DW'(signed'({1'b0, base}));
        cor_start = 1'b0;
        cor_phi   = PHW'(r_head);
        case (r_state)
            ddo_pkg::ST_MUL_TR: begin
                mul_en = 1'b1;
                mul_a  = MW'(diff_r);
                mul_b  = MW'(signed'({1'b0, r_rscale}));
            end
            ddo_pkg::ST_MUL_TL: begin
                mul_en = 1'b1;
                mul_a  = MW'(diff_l);
                mul_b  = MW'(signed'({1'b0, r_lscale}));
            end
            ddo_pkg::ST_MUL_D1: begin
                // right travel weighted by the left arm
                mul_en = 1'b1;
                mul_a  = MW'(r_tr);
                mul_b  = MW'(signed'({1'b0, r_larm}));
            end
            ddo_pkg::ST_MUL_D2: begin
                mul_en = 1'b1;
                mul_a  = MW'(r_tl);
                mul_b  = MW'(signed'({1'b0, r_rarm}));
            end
            ddo_pkg::ST_SUM: begin
                // zero wheel base: zero step, heading-only CORDIC
                if (base != '0) div_start = 1'b1;
                else            cor_start = 1'b1;
            end
            ddo_pkg::ST_DIV_D: begin
                div_num   = num_a;
                div_start = div_done;
            end
            ddo_pkg::ST_DIV_A: begin
                cor_start = div_done;
                if (use_arc) cor_phi = PHW'(ang_c >>> 1);
                else         cor_phi = PHW'(ang_c >>> 1) + PHW'(r_head);
            end
            ddo_pkg::ST_MUL_C: begin
                mul_en = 1'b1;
                mul_a  = MW'(r_dist);
                mul_b  = MW'(sn);
            end
            ddo_pkg::ST_DIVC_GO: begin
                div_start = 1'b1;
                div_num   = r_prod[NW-1:0];
                div_den   = DW'(r_ang) <<< 5;
            end
            ddo_pkg::ST_DIV_C: begin
                cor_start = div_done;
                cor_phi   = PHW'(r_ang >>> 1) + PHW'(r_head);
            end
            ddo_pkg::ST_MUL_X: begin
                mul_en = 1'b1;
                mul_a  = MW'(sn);
                mul_b  = MW'(r_chord);
            end
            ddo_pkg::ST_MUL_Y: begin
                mul_en = 1'b1;
                mul_a  = MW'(cs);
                mul_b  = MW'(r_chord);
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddo_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rrev   <= 1'b0;
            r_lrev   <= 1'b0;
            r_rscale <= 24'd1677722;
            r_lscale <= 24'd1677722;
            r_rarm   <= 20'd33280;
            r_larm   <= 20'd33280;
            r_thresh <= 24'd14641;
            r_offset <= 16'd10000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ddo_pkg::CFG_RIGHT_REVERSE: r_rrev   <= i_cfg_data[0];
                ddo_pkg::CFG_LEFT_REVERSE:  r_lrev   <= i_cfg_data[0];
                ddo_pkg::CFG_RIGHT_SCALE:   r_rscale <= i_cfg_data;
                ddo_pkg::CFG_LEFT_SCALE:    r_lscale <= i_cfg_data;
                ddo_pkg::CFG_RIGHT_ARM:     r_rarm   <= i_cfg_data[19:0];
                ddo_pkg::CFG_LEFT_ARM:      r_larm   <= i_cfg_data[19:0];
                ddo_pkg::CFG_THRESHOLD:     r_thresh <= i_cfg_data;
                ddo_pkg::CFG_COUNT_OFFSET:  r_offset <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // payload datapath
    always_ff @(posedge i_clk) begin
        if (mul_en) r_prod <= mul_a * mul_b;
        if (in_xfer) begin
            r_cnt_r <= i_right_count;
            r_cnt_l <= i_left_count;
        end
        case (r_state)
            ddo_pkg::ST_MUL_TL: r_tr  <= trav;
            ddo_pkg::ST_MUL_D1: r_tl  <= trav;
            ddo_pkg::ST_MUL_D2: r_acc <= r_prod[55:0];
            ddo_pkg::ST_SUM: begin
                if (base == '0) begin
                    r_dist  <= '0;
                    r_ang   <= '0;
                    r_chord <= '0;
                end
            end
            ddo_pkg::ST_DIV_D: if (div_done) r_dist <= dist_c;
            ddo_pkg::ST_DIV_A: begin
                if (div_done) begin
                    r_ang   <= ang_c;
                    r_chord <= r_dist;
                end
            end
            ddo_pkg::ST_DIV_C: if (div_done) r_chord <= chord_c;
            default: ;
        endcase
    end

    // position and heading state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_head  <= '0;
        end else begin
            if (r_state == ddo_pkg::ST_MUL_Y) begin
                r_pos_x <= r_pos_x + dx_full[PW-1:0];
            end
            if (r_state == ddo_pkg::ST_UPD && out_free) begin
                r_pos_y <= r_pos_y + dy_full[PW-1:0];
                r_head  <= head_c[27:0];
            end
        end
    end

    // output register
    assign py64 = 64'(signed'(r_pos_y + dy_full[PW-1:0]));
    assign px64 = 64'(r_pos_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ddo_pkg::ST_UPD && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ddo_pkg::ST_UPD && out_free) begin
            r_ox <= px64[47:0];
            r_oy <= py64[47:0];
            r_oh <= head_c[27:0];
            r_od <= r_dist;
            r_oa <= r_ang;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_x_position    = r_ox;
    assign o_y_position    = r_oy;
    assign o_heading       = r_oh;
    assign o_step_distance = r_od;
    assign o_step_angle    = r_oa;

    // ---------------- shared units ----------------
    ddo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_phi   (cor_phi),
        .o_done  (cor_done),
        .o_sin   (sn),
        .o_cos   (cs)
    );

endmodule

>>> dv/tb_differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// tb_differential_drive_odometry
// Self-checking bench for the arc-update odometry block. A scoreboard class
// mirrors registers and pose state, predicts each update from the wheel
// counts and checks every result transfer field by field, in order.
// ----------------------------------------------------------------------------
module tb_differential_drive_odometry;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [47:0] x;
        logic [47:0] y;
        logic [27:0] head;
        logic [31:0] step_d;
        logic [27:0] ang;
    } t_pose_upd;

    // ------------------------------------------------------------------------
    // Pose scoreboard: register mirror, pose state, queue of pending updates
    // ------------------------------------------------------------------------
    class pose_scoreboard;
        bit        rev_r, rev_l;
        longint    scale_r, scale_l, arm_r, arm_l, thresh, offset;
        logic [47:0] px, py;
        longint    head_acc;
        t_pose_upd pending[$];
        int        mismatches, results;
        longint    atan_tab[32];

        function void reset_state();
            rev_r = 0; rev_l = 0;
            scale_r = 1677722; scale_l = 1677722;
            arm_r = 33280; arm_l = 33280;
            thresh = 14641; offset = 10000;
            px = '0; py = '0; head_acc = 0;
            atan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687,
                33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
                262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024,
                512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};
        endfunction

        function void write_reg(logic [2:0] idx, logic [23:0] d);
            case (idx)
                ddo_pkg::CFG_RIGHT_REVERSE: rev_r = d[0];
                ddo_pkg::CFG_LEFT_REVERSE:  rev_l = d[0];
                ddo_pkg::CFG_RIGHT_SCALE:   scale_r = longint'(d);
                ddo_pkg::CFG_LEFT_SCALE:    scale_l = longint'(d);
                ddo_pkg::CFG_RIGHT_ARM:     arm_r = longint'(d[19:0]);
                ddo_pkg::CFG_LEFT_ARM:      arm_l = longint'(d[19:0]);
                ddo_pkg::CFG_THRESHOLD:     thresh = longint'(d);
                ddo_pkg::CFG_COUNT_OFFSET:  offset = longint'(d[15:0]);
                default: ;
            endcase
        endfunction

        function longint sat(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // rotation-mode CORDIC after folding into [-pi/2, pi/2]
        function void sincos(longint phi, output longint sn, output longint cs);
            longint x, y, z, nx;
            bit     flip;
            x = ddo_pkg::CORDIC_GAIN; y = 0; flip = 0;
            if (phi > ddo_pkg::PI_Q) phi -= ddo_pkg::TWO_PI_Q;
            if (phi > ddo_pkg::PI_Q) phi -= ddo_pkg::TWO_PI_Q;
            if (phi < -ddo_pkg::PI_Q) phi += ddo_pkg::TWO_PI_Q;
            if (phi < -ddo_pkg::PI_Q) phi += ddo_pkg::TWO_PI_Q;
            if (phi > ddo_pkg::HALF_PI_Q) begin
                phi -= ddo_pkg::PI_Q; flip = 1;
            end else if (phi < -ddo_pkg::HALF_PI_Q) begin
                phi += ddo_pkg::PI_Q; flip = 1;
            end
            z = phi * 64;
            for (int i = 0; i < 24; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
                end else begin
                    nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
                end
                x = nx;
            end
            sn = flip ? -y : y;
            cs = flip ? -x : x;
        endfunction

        function longint wheel(logic [15:0] cnt, longint scale, bit rev);
            longint t;
            t = ((longint'(cnt) - offset) * scale) >>> 8;
            return rev ? -t : t;
        endfunction

        function void note_input(logic [15:0] rc, logic [15:0] lc);
            longint tr, tl, base, step_d, ang, chord, sn, cs, dx, dy;
            longint lo32, hi32;
            t_pose_upd e;
            lo32 = -64'sh8000_0000;
            hi32 = 64'sh7FFF_FFFF;
            tr = wheel(rc, scale_r, rev_r);
            tl = wheel(lc, scale_l, rev_l);
            base = arm_r + arm_l;
            step_d = 0; ang = 0;
            if (base != 0) begin
                step_d = sat((tl * arm_r + tr * arm_l) / base, lo32, hi32);
                ang = sat(((tr - tl) * 65536) / base, -ddo_pkg::TWO_PI_Q,
                          ddo_pkg::TWO_PI_Q);
            end
            chord = step_d;
            // arc chord only for non-negative turns at or above threshold
            if (ang >= thresh && ang != 0) begin
                sincos(ang >>> 1, sn, cs);
                chord = sat((step_d * sn) / (ang * 32), lo32, hi32);
            end
            sincos((ang >>> 1) + head_acc, sn, cs);
            dx = (-(sn * chord)) >>> 30;
            dy = (cs * chord) >>> 30;
            px = px + dx[47:0];
            py = py + dy[47:0];
            head_acc = (head_acc + ang) % ddo_pkg::TWO_PI_Q;
            e.x = px; e.y = py; e.head = head_acc[27:0];
            e.step_d = step_d[31:0]; e.ang = ang[27:0];
            pending.push_back(e);
        endfunction

        function void check_result(t_pose_upd got);
            t_pose_upd e;
            results++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %p", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch #%0d: exp x=%0d y=%0d h=%0d d=%0d a=%0d",
                        results, $signed(e.x), $signed(e.y), $signed(e.head),
                        $signed(e.step_d), $signed(e.ang));
                    $display("              got x=%0d y=%0d h=%0d d=%0d a=%0d",
                        $signed(got.x), $signed(got.y), $signed(got.head),
                        $signed(got.step_d), $signed(got.ang));
                end
            end
        endfunction
    endclass

    localparam int LIMIT       = 3_000_000; // cycles
    localparam int HOLD_CYCLES = 3000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [15:0]        i_right_count = '0;
    logic [15:0]        i_left_count = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [47:0] o_x_position, o_y_position;
    logic signed [27:0] o_heading, o_step_angle;
    logic signed [31:0] o_step_distance;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [23:0]        i_cfg_data = '0;

    pose_scoreboard sb;
    int     cycles, items, settings;
    bit     calm;                       // no idling on either side
    bit     hold_go;                    // receiver hold-off request

    differential_drive_odometry u_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_differential_drive_odometry: done, errors");
            $finish;
        end
    end

    // result side: random stall, or one long hold-off when requested
    int hold_left;
    bit hold_taken;
    always @(negedge i_clk) begin
        if (hold_go && !hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 11);
        end
    end

    // every result transfer is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result('{o_x_position, o_y_position, o_heading,
                              o_step_distance, o_step_angle});
    end

    // one encoder sample pair; returns after the transfer
    task automatic send_pair(logic [15:0] rc, logic [15:0] lc);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 11) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_right_count = rc;
        i_left_count  = lc;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(rc, lc);
        items++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [23:0] d);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, d);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // wait until the block has drained, then a latency's worth of slack
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic load_setting(logic rr, logic lr, logic [23:0] rs, logic [23:0] ls,
                                logic [19:0] ra, logic [19:0] la, logic [23:0] th,
                                logic [15:0] off);
        drain();
        write_cfg(ddo_pkg::CFG_RIGHT_REVERSE, {23'd0, rr});
        write_cfg(ddo_pkg::CFG_LEFT_REVERSE,  {23'd0, lr});
        write_cfg(ddo_pkg::CFG_RIGHT_SCALE,   rs);
        write_cfg(ddo_pkg::CFG_LEFT_SCALE,    ls);
        write_cfg(ddo_pkg::CFG_RIGHT_ARM,     {4'd0, ra});
        write_cfg(ddo_pkg::CFG_LEFT_ARM,      {4'd0, la});
        write_cfg(ddo_pkg::CFG_THRESHOLD,     th);
        write_cfg(ddo_pkg::CFG_COUNT_OFFSET,  off);
        settings++;
    endtask

    // mostly plausible motion around the offset, some full-range noise
    task automatic random_pairs(int n);
        logic [15:0] off, rc, lc;
        int          spread;
        for (int k = 0; k < n; k++) begin
            off = sb.offset[15:0];
            if ($urandom_range(99) < 75) begin
                spread = 1 << $urandom_range(12);
                rc = off + 16'($urandom_range(2 * spread) - spread);
                lc = ($urandom_range(3) == 0) ? rc
                                              : off + 16'($urandom_range(2 * spread) - spread);
            end else begin
                rc = 16'($urandom);
                lc = 16'($urandom);
            end
            send_pair(rc, lc);
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        calm = 0;
        hold_go = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed at reset defaults: straight, turns both ways, count extremes
        send_pair(16'd10000, 16'd10000);
        send_pair(16'd10100, 16'd10100);
        send_pair(16'd10050, 16'd10000);      // positive turn, arc chord
        send_pair(16'd10000, 16'd10050);      // negative turn, straight chord
        send_pair(16'd10001, 16'd10000);      // tiny turn below threshold
        send_pair(16'hFFFF, 16'h0000);        // saturated angle step
        send_pair(16'h0000, 16'hFFFF);
        send_pair(16'hFFFF, 16'hFFFF);
        send_pair(16'h0000, 16'h0000);
        send_pair(16'hAAAA, 16'h5555);
        send_pair(16'h5555, 16'hAAAA);
        for (int k = 0; k < 8; k++)
            send_pair(16'd10400, 16'd10000);  // repeated positive arc turns

        // zero threshold, reversed wheels, max scales, unit arms
        load_setting(1, 1, 24'hFFFFFF, 24'hFFFFFF, 20'd1, 20'd1, 24'd0, 16'd0);
        send_pair(16'd0, 16'd0);              // zero angle with zero threshold
        send_pair(16'hFFFF, 16'h0000);
        send_pair(16'h0000, 16'hFFFF);
        random_pairs(150);

        // pressure: receiver holds off while items keep coming
        load_setting(0, 1, 24'd1677722, 24'd1000000, 20'hFFFFF, 20'd33280,
                     24'hFFFFFF, 16'hFFFF);
        hold_go = 1;
        random_pairs(150);

        // no idling at all on either side
        load_setting(1, 0, 24'd0, 24'd5000000, 20'd40000, 20'hFFFFF, 24'd100, 16'd32768);
        calm = 1;
        random_pairs(180);
        calm = 0;

        load_setting(0, 0, 24'd1677722, 24'd1677722, 20'd33280, 20'd33280,
                     24'd14641, 16'd10000);
        random_pairs(180);

        load_setting(0, 0, 24'd3000000, 24'd2900000, 20'd25000, 20'd27000,
                     24'd1, 16'd20000);
        random_pairs(180);

        load_setting(1, 1, 24'd800000, 24'd800000, 20'd60000, 20'd60000,
                     24'd50000, 16'd1);
        random_pairs(180);

        // end of stimulus: drain, then latency slack
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);

        $display("covered %0d sample pairs over %0d register settings, %0d results checked",
                 items, settings + 1, sb.results);
        $display("including a long receiver hold-off and an idle-free stretch");
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("tb_differential_drive_odometry: done, clean");
        end else begin
            $display("%0d mismatches, %0d predictions left", sb.mismatches,
                     sb.pending.size());
            $display("tb_differential_drive_odometry: done, errors");
        end
        $finish;
    end
endmodule
